[rtl/brdc_pkg.sv]
// shared types, codes and constants of the balance robot drive controller
`timescale 1ns / 1ps

package brdc_pkg;

  // opcodes of an input transfer
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_TOGGLE = 2'd1;
  localparam logic [1:0] OP_STOP   = 2'd2;
  localparam logic [1:0] OP_RUN    = 2'd3;

  // register indexes, one 32-bit word each at byte address 4*i
  localparam logic [2:0] REG_OFFSET = 3'd0;
  localparam logic [2:0] REG_BAL_KP = 3'd1;
  localparam logic [2:0] REG_BAL_KD = 3'd2;
  localparam logic [2:0] REG_VEL_KP = 3'd3;
  localparam logic [2:0] REG_VEL_KI = 3'd4;
  localparam logic [2:0] REG_MAXDRV = 3'd5;
  localparam logic [2:0] REG_TILT   = 3'd6;

  // datapath step codes of one control tick
  localparam logic [3:0] STEP_BAL_P    = 4'd0;
  localparam logic [3:0] STEP_BAL_D    = 4'd1;
  localparam logic [3:0] STEP_FILT_OLD = 4'd2;
  localparam logic [3:0] STEP_FILT_NEW = 4'd3;
  localparam logic [3:0] STEP_FILT     = 4'd4;
  localparam logic [3:0] STEP_INTEG    = 4'd5;
  localparam logic [3:0] STEP_VEL_I    = 4'd6;
  localparam logic [3:0] STEP_VEL      = 4'd7;
  localparam logic [3:0] STEP_DRIVE    = 4'd8;
  localparam logic [3:0] STEP_LAST     = STEP_DRIVE;

  // filter weights 0.8 and 0.2 over 2^14, integral limit 10000 in q.8
  localparam logic signed [16:0] FILT_OLD = 17'sd13107;
  localparam logic signed [16:0] FILT_NEW = 17'sd3277;
  localparam logic signed [26:0] INTEG_LIMIT = 27'sd2560000;

  typedef struct packed {
    logic signed [16:0] balance_offset;
    logic [15:0]        bal_p_gain;
    logic [15:0]        bal_d_gain;
    logic [15:0]        vel_p_gain;
    logic [15:0]        vel_i_gain;
    logic [15:0]        max_drive;
    logic [15:0]        tilt_limit;
  } cfg_t;

  typedef struct packed {
    logic       accept;
    logic       step_en;
    logic [3:0] step;
    logic       write_out;
  } cmd_t;

endpackage

[rtl/brdc_regs.sv]
// configuration registers behind the apb-style port
`timescale 1ns / 1ps

module brdc_regs
  import brdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.balance_offset <= -17'sd896;
      cfg.bal_p_gain     <= 16'd64000;
      cfg.bal_d_gain     <= 16'd256;
      cfg.vel_p_gain     <= 16'd768;
      cfg.vel_i_gain     <= 16'd1311;
      cfg.max_drive      <= 16'd7200;
      cfg.tilt_limit     <= 16'd8960;
    end else if (wr_en) begin
      case (reg_idx)
        REG_OFFSET: cfg.balance_offset <= $signed(pwdata[16:0]);
        REG_BAL_KP: cfg.bal_p_gain     <= pwdata[15:0];
        REG_BAL_KD: cfg.bal_d_gain     <= pwdata[15:0];
        REG_VEL_KP: cfg.vel_p_gain     <= pwdata[15:0];
        REG_VEL_KI: cfg.vel_i_gain     <= pwdata[15:0];
        REG_MAXDRV: cfg.max_drive      <= pwdata[15:0];
        REG_TILT:   cfg.tilt_limit     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_OFFSET: prdata = {{15{cfg.balance_offset[16]}}, cfg.balance_offset};
      REG_BAL_KP: prdata = {16'd0, cfg.bal_p_gain};
      REG_BAL_KD: prdata = {16'd0, cfg.bal_d_gain};
      REG_VEL_KP: prdata = {16'd0, cfg.vel_p_gain};
      REG_VEL_KI: prdata = {16'd0, cfg.vel_i_gain};
      REG_MAXDRV: prdata = {16'd0, cfg.max_drive};
      REG_TILT:   prdata = {16'd0, cfg.tilt_limit};
      default:    prdata = 32'd0;
    endcase
  end

endmodule

[rtl/brdc_ctrl.sv]
// controller state machine: accept, step sequencing and result hand-off
`timescale 1ns / 1ps

module brdc_ctrl
  import brdc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] opcode,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output cmd_t       cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [3:0] step;
  logic [3:0] step_next;

  always_comb begin
    state_next    = state;
    step_next     = step;
    cmd.accept    = 1'b0;
    cmd.step_en   = 1'b0;
    cmd.step      = step;
    cmd.write_out = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          step_next  = STEP_BAL_P;
          state_next = (opcode == OP_TICK) ? ST_CALC : ST_EMIT;
        end
      end
      ST_CALC: begin
        cmd.step_en = 1'b1;
        if (step == STEP_LAST) begin
          state_next = ST_EMIT;
        end else begin
          step_next = step + 4'd1;
        end
      end
      ST_EMIT: begin
        // output register free or being drained this cycle
        if (!out_valid || !out_stall) begin
          cmd.write_out = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= STEP_BAL_P;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (cmd.write_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign in_stall = (state != ST_IDLE);

endmodule

[rtl/brdc_dp.sv]
// datapath: shared multiplier, accumulator, loop state and result registers
`timescale 1ns / 1ps

module brdc_dp
  import brdc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  cmd_t               cmd,
  input  logic [1:0]         opcode,
  input  logic signed [16:0] tilt_angle,
  input  logic signed [15:0] gyro_rate,
  input  logic signed [15:0] enc_left,
  input  logic signed [15:0] enc_right,
  output logic signed [16:0] drive_left,
  output logic signed [16:0] drive_right,
  output logic               stopped
);

  logic               motors_stopped;
  logic signed [25:0] speed_filtered;
  logic signed [22:0] speed_integral;

  logic signed [17:0] bias;
  logic signed [15:0] gyro;
  logic signed [16:0] enc_sum;
  logic signed [42:0] prod;
  logic signed [52:0] acc;
  logic signed [26:0] bal;
  logic signed [28:0] vel;
  logic signed [16:0] res_drive;

  logic signed [25:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [42:0] mul_out;
  logic signed [52:0] prod_ext;
  logic signed [52:0] prod_sh8;
  logic signed [52:0] acc_add_sh8;
  logic signed [52:0] acc_add;
  logic signed [52:0] bal_round;
  logic signed [52:0] vel_round;
  logic signed [26:0] integ_sum;
  logic signed [29:0] diff;
  logic signed [29:0] lim;
  logic [17:0]        angle_mag;
  logic               tilt_over;

  // tilt magnitude check at accept
  assign angle_mag = tilt_angle[16] ? (18'd0 - {tilt_angle[16], tilt_angle})
                                    : {1'b0, tilt_angle};
  assign tilt_over = angle_mag > {2'b00, cfg.tilt_limit};

  always_comb begin
    case (cmd.step)
      STEP_BAL_P: begin
        mul_a = {{8{bias[17]}}, bias};
        mul_b = $signed({1'b0, cfg.bal_p_gain});
      end
      STEP_BAL_D: begin
        mul_a = {{10{gyro[15]}}, gyro};
        mul_b = $signed({1'b0, cfg.bal_d_gain});
      end
      STEP_FILT_OLD: begin
        mul_a = speed_filtered;
        mul_b = FILT_OLD;
      end
      STEP_FILT_NEW: begin
        mul_a = {{9{enc_sum[16]}}, enc_sum};
        mul_b = FILT_NEW;
      end
      STEP_INTEG: begin
        mul_a = speed_filtered;
        mul_b = $signed({1'b0, cfg.vel_p_gain});
      end
      STEP_VEL_I: begin
        mul_a = {{3{speed_integral[22]}}, speed_integral};
        mul_b = $signed({1'b0, cfg.vel_i_gain});
      end
      default: begin
        mul_a = speed_filtered;
        mul_b = FILT_OLD;
      end
    endcase
  end

  assign mul_out     = mul_a * mul_b;
  assign prod_ext    = {{10{prod[42]}}, prod};
  assign prod_sh8    = {{2{prod[42]}}, prod, 8'd0};
  assign acc_add_sh8 = acc + prod_sh8;
  assign acc_add     = acc + prod_ext;
  // truncation towards zero: bias negative values before the shift
  assign bal_round   = acc[52] ? (acc + 53'sd65535) : acc;
  assign vel_round   = acc_add[52] ? (acc_add + 53'sd16777215) : acc_add;
  assign integ_sum   = {{4{speed_integral[22]}}, speed_integral}
                     + {speed_filtered[25], speed_filtered};
  assign diff        = {{3{bal[26]}}, bal} - {vel[28], vel};
  assign lim         = {14'd0, cfg.max_drive};

  always_ff @(posedge clk) begin
    if (rst) begin
      motors_stopped <= 1'b0;
      speed_filtered <= '0;
      speed_integral <= '0;
    end else begin
      if (cmd.accept) begin
        case (opcode)
          OP_TOGGLE: motors_stopped <= !motors_stopped;
          OP_STOP:   motors_stopped <= 1'b1;
          OP_RUN:    motors_stopped <= 1'b0;
          default:   motors_stopped <= motors_stopped || tilt_over;
        endcase
      end
      if (cmd.step_en && cmd.step == STEP_FILT) begin
        speed_filtered <= acc_add_sh8[39:14];
      end
      if (cmd.step_en && cmd.step == STEP_INTEG) begin
        if (integ_sum > INTEG_LIMIT) begin
          speed_integral <= INTEG_LIMIT[22:0];
        end else if (integ_sum < -INTEG_LIMIT) begin
          speed_integral <= 23'(-INTEG_LIMIT);
        end else begin
          speed_integral <= integ_sum[22:0];
        end
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      bias      <= {tilt_angle[16], tilt_angle}
                 - {cfg.balance_offset[16], cfg.balance_offset};
      gyro      <= gyro_rate;
      enc_sum   <= {enc_left[15], enc_left} + {enc_right[15], enc_right};
      res_drive <= '0;
    end
    if (cmd.step_en) begin
      prod <= mul_out;
      case (cmd.step)
        STEP_BAL_D:    acc <= prod_ext;
        STEP_FILT_OLD: acc <= acc_add_sh8;
        STEP_FILT_NEW: begin
          bal <= bal_round[42:16];
          acc <= prod_ext;
        end
        STEP_VEL_I:    acc <= prod_sh8;
        STEP_VEL:      vel <= vel_round[52:24];
        STEP_DRIVE: begin
          if (motors_stopped) begin
            res_drive <= '0;
          end else if (diff > lim) begin
            res_drive <= lim[16:0];
          end else if (diff < -lim) begin
            res_drive <= 17'(-lim);
          end else begin
            res_drive <= diff[16:0];
          end
        end
        default: ;
      endcase
    end
    if (cmd.write_out) begin
      drive_left  <= res_drive;
      drive_right <= res_drive;
      stopped     <= motors_stopped;
    end
  end

endmodule

[rtl/balance_robot_drive_controller.sv]
// top level of the two-wheel balance robot drive controller
`timescale 1ns / 1ps

// usage
// - input channel (in_valid / in_stall) carries opcode, tilt_angle, gyro_rate and
//   the two encoder deltas; a transfer happens when in_valid is high and in_stall low
// - opcode 0 runs a control tick: tilt check, balance pd term, velocity low-pass,
//   clamped integral and velocity pi term, then both wheel drives
// - opcodes 1 to 3 toggle, set or clear the stopped flag and return zero drives
// - output channel (out_valid / out_stall) returns drive_left, drive_right and stopped,
//   one result per input transfer, held stable while out_stall is high
// - one item at a time: a control tick runs nine steps of the shared 26x17 multiplier
//   and accumulator, then loads the output register; a stop opcode goes straight to
//   the output register; the next transfer is taken after the result is loaded
// - a result waits in the output register while the receiver stalls; the block
//   finishes the next item and holds in_stall high until that register drains
// - reset (rst, synchronous) restores the register defaults, clears the stopped
//   flag, filter and integral, and empties the output register
// - configuration through the apb-style port at byte address 4*i, always ready;
//   write it only while no item is in flight

module balance_robot_drive_controller
  import brdc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic signed [16:0] tilt_angle,
  input  logic signed [15:0] gyro_rate,
  input  logic signed [15:0] enc_left,
  input  logic signed [15:0] enc_right,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [16:0] drive_left,
  output logic signed [16:0] drive_right,
  output logic               stopped,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t cfg;
  cmd_t cmd;

  // register bank
  brdc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: owns both handshakes
  brdc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .opcode    (opcode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // arithmetic and loop state
  brdc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .opcode      (opcode),
    .tilt_angle  (tilt_angle),
    .gyro_rate   (gyro_rate),
    .enc_left    (enc_left),
    .enc_right   (enc_right),
    .drive_left  (drive_left),
    .drive_right (drive_right),
    .stopped     (stopped)
  );

  // a stopped result never drives the motors
  a_stopped_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && stopped |-> (drive_left == 17'sd0) && (drive_right == 17'sd0))
    else $error("drive not zero while stopped");

  // after a transfer the block is busy with that item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again before the item finished");

  // a result is only loaded when the output register is free or draining
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.write_out |-> !out_valid || !out_stall)
    else $error("result loaded over a waiting result");

endmodule

[tb/balance_robot_drive_controller_tb.sv]
// self-checking testbench of the balance robot drive controller: directed table, then random
`timescale 1ns / 1ps

module balance_robot_drive_controller_tb;
  import brdc_pkg::*;

  // timing of the bench
  localparam int N_PHASES        = 6;
  localparam int ITEMS_PER_PHASE = 255;
  localparam int DRAIN_CYCLES    = 24;    // idle slack after the outstanding results have drained
  localparam int QUIET_LIMIT     = 1000;  // cycles without any transfer before giving up
  localparam int REPORT_LIMIT    = 10;

  // velocity loop constants: 0.8 / 0.2 over 2^14, integral held within 10000 in q.8
  localparam longint FILT_KEEP   = 13107;
  localparam longint FILT_TAKE   = 3277;
  localparam longint SPEED_LIMIT = 2560000;

  typedef struct {
    logic [1:0]         op;
    logic signed [16:0] angle;
    logic signed [15:0] gyro;
    logic signed [15:0] enc_l;
    logic signed [15:0] enc_r;
  } tick_item_t;

  typedef struct {
    logic signed [16:0] left;
    logic signed [16:0] right;
    logic               halted;
  } drive_result_t;

  // one row of the directed table; known rows carry the result typed in by hand
  typedef struct {
    tick_item_t    item;
    bit            known;
    drive_result_t result;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         opcode = OP_TICK;
  logic signed [16:0] tilt_angle = '0;
  logic signed [15:0] gyro_rate = '0;
  logic signed [15:0] enc_left = '0;
  logic signed [15:0] enc_right = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [16:0] drive_left;
  logic signed [16:0] drive_right;
  logic               stopped;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // copy of the block's settings and state used to work out expected drives
  cfg_t   gain_cfg;
  bit     motors_off;
  longint speed_lp;
  longint speed_sum;

  drive_result_t pending_drives[$];
  dir_row_t      directed_rows[$];
  drive_result_t want;

  int  errors = 0;
  int  results_checked = 0;
  int  ticks_sent = 0;
  int  commands_sent = 0;
  int  stall_run = 0;
  int  quiet = 0;
  bit  idle_on = 1'b1;

  balance_robot_drive_controller dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .tilt_angle  (tilt_angle),
    .gyro_rate   (gyro_rate),
    .enc_left    (enc_left),
    .enc_right   (enc_right),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .drive_left  (drive_left),
    .drive_right (drive_right),
    .stopped     (stopped),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // drive predictor
  // ---------------------------------------------------------------------------

  function automatic cfg_t cfg_defaults();
    cfg_t c;
    c.balance_offset = -17'sd896;
    c.bal_p_gain     = 16'd64000;
    c.bal_d_gain     = 16'd256;
    c.vel_p_gain     = 16'd768;
    c.vel_i_gain     = 16'd1311;
    c.max_drive      = 16'd7200;
    c.tilt_limit     = 16'd8960;
    return c;
  endfunction

  // shift right rounding toward zero
  function automatic longint trunc_shr(input longint x, input int sh);
    return (x < 0) ? -((-x) >>> sh) : (x >>> sh);
  endfunction

  function automatic longint clamp_abs(input longint x, input longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  function automatic drive_result_t predict_drive(input tick_item_t it);
    drive_result_t res;
    longint angle, mag, bias, bal, vel, sum, drv;
    longint off, kp, kd, vkp, vki, mx, lim;
    off = $signed(gain_cfg.balance_offset);
    kp  = gain_cfg.bal_p_gain;
    kd  = gain_cfg.bal_d_gain;
    vkp = gain_cfg.vel_p_gain;
    vki = gain_cfg.vel_i_gain;
    mx  = gain_cfg.max_drive;
    lim = gain_cfg.tilt_limit;
    drv = 0;
    case (it.op)
      OP_TOGGLE: motors_off = !motors_off;
      OP_STOP:   motors_off = 1'b1;
      OP_RUN:    motors_off = 1'b0;
      default: begin
        angle = it.angle;
        mag = (angle < 0) ? -angle : angle;
        // tilt trip latches only while running, ahead of the drive
        if (!motors_off && mag > lim) motors_off = 1'b1;
        bias = angle - off;
        bal = trunc_shr(bias * kp + longint'(it.gyro) * kd * 256, 16);
        sum = it.enc_l;
        sum += it.enc_r;
        // low-pass and integral run on every tick, stopped or not
        speed_lp = (speed_lp * FILT_KEEP + sum * 256 * FILT_TAKE) >>> 14;
        speed_sum = clamp_abs(speed_sum + speed_lp, SPEED_LIMIT);
        vel = trunc_shr(speed_lp * vkp * 256 + speed_sum * vki, 24);
        if (!motors_off) drv = clamp_abs(bal - vel, mx);
      end
    endcase
    res.left   = 17'(drv);
    res.right  = 17'(drv);
    res.halted = motors_off;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic signed [15:0] sat16(input int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return 16'(v);
  endfunction

  // idle length: mostly short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int pick_gap();
    if (!idle_on || $urandom_range(0, 1) == 0) return 0;
    return idle_len();
  endfunction

  function automatic dir_row_t dir_row(input logic [1:0] op, input int angle, input int gyro,
                                       input int enc_l, input int enc_r,
                                       input bit known, input int drv, input bit halted);
    dir_row_t row;
    row.item.op        = op;
    row.item.angle     = 17'(angle);
    row.item.gyro      = 16'(gyro);
    row.item.enc_l     = 16'(enc_l);
    row.item.enc_r     = 16'(enc_r);
    row.known          = known;
    row.result.left    = 17'(drv);
    row.result.right   = 17'(drv);
    row.result.halted  = halted;
    return row;
  endfunction

  function automatic logic signed [16:0] pick_angle();
    int r, v, lim;
    r = $urandom_range(0, 99);
    lim = gain_cfg.tilt_limit;
    if (r < 65) begin
      // near the balance point, so the robot keeps running
      v = int'($signed(gain_cfg.balance_offset)) + int'($urandom_range(0, 1600)) - 800;
    end else if (r < 85) begin
      v = int'($urandom_range(0, 92160)) - 46080;
    end else if (r < 93) begin
      // right on the trip threshold or one step past it
      v = lim + int'($urandom_range(0, 1));
      if ($urandom_range(0, 1) == 1) v = -v;
    end else begin
      v = ($urandom_range(0, 1) == 1) ? 46080 : -46080;
    end
    if (v > 46080) v = 46080;
    if (v < -46080) v = -46080;
    return 17'(v);
  endfunction

  function automatic logic signed [15:0] pick_gyro();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return sat16(int'($urandom_range(0, 1000)) - 500);
    if (r < 90) return 16'($urandom());
    return ($urandom_range(0, 1) == 1) ? 16'sd32767 : -16'sd32768;
  endfunction

  // encoder speed trend, held for a while so the integral can wind up to its clamp
  function automatic int pick_trend();
    int v;
    case ($urandom_range(0, 3))
      0:       v = 0;
      1:       v = $urandom_range(0, 2000);
      2:       v = 32767;
      default: v = $urandom_range(0, 16000);
    endcase
    return ($urandom_range(0, 1) == 1) ? -v : v;
  endfunction

  function automatic logic signed [15:0] pick_encoder(input int trend);
    if ($urandom_range(0, 9) == 0) return 16'($urandom());
    return sat16(trend + int'($urandom_range(0, 400)) - 200);
  endfunction

  function automatic tick_item_t random_item(input int trend);
    tick_item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 82)      it.op = OP_TICK;
    else if (r < 87) it.op = OP_TOGGLE;
    else if (r < 91) it.op = OP_STOP;
    else             it.op = OP_RUN;
    it.angle = pick_angle();
    it.gyro  = pick_gyro();
    it.enc_l = pick_encoder(trend);
    it.enc_r = pick_encoder(trend);
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // bus tasks
  // ---------------------------------------------------------------------------

  // setup cycle, access cycle, then back to idle on the register port
  task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_OFFSET: gain_cfg.balance_offset = value[16:0];
      REG_BAL_KP: gain_cfg.bal_p_gain     = value[15:0];
      REG_BAL_KD: gain_cfg.bal_d_gain     = value[15:0];
      REG_VEL_KP: gain_cfg.vel_p_gain     = value[15:0];
      REG_VEL_KI: gain_cfg.vel_i_gain     = value[15:0];
      REG_MAXDRV: gain_cfg.max_drive      = value[15:0];
      default:    gain_cfg.tilt_limit     = value[15:0];
    endcase
  endtask

  task automatic write_all(input cfg_t c);
    apb_write(REG_OFFSET, {{15{c.balance_offset[16]}}, c.balance_offset});
    apb_write(REG_BAL_KP, {16'd0, c.bal_p_gain});
    apb_write(REG_BAL_KD, {16'd0, c.bal_d_gain});
    apb_write(REG_VEL_KP, {16'd0, c.vel_p_gain});
    apb_write(REG_VEL_KI, {16'd0, c.vel_i_gain});
    apb_write(REG_MAXDRV, {16'd0, c.max_drive});
    apb_write(REG_TILT,   {16'd0, c.tilt_limit});
  endtask

  // offer one item, hold it while stalled, and note what it should produce
  task automatic run_item(input tick_item_t it, input bit known, input drive_result_t typed);
    drive_result_t res;
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= it.op;
    tilt_angle <= it.angle;
    gyro_rate  <= it.gyro;
    enc_left   <= it.enc_l;
    enc_right  <= it.enc_r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // transfer taken at this edge
    res = predict_drive(it);
    pending_drives.push_back(known ? typed : res);
    if (it.op == OP_TICK) ticks_sent++;
    else commands_sent++;
  endtask

  // let every outstanding result drain, then give the block a little slack
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: random stall and the result checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst || !idle_on) begin
      out_stall <= 1'b0;
      stall_run = 0;
    end else if (stall_run > 0) begin
      stall_run--;
    end else if ($urandom_range(0, 99) < 30) begin
      out_stall <= 1'b1;
      stall_run = idle_len();
    end else begin
      out_stall <= 1'b0;
      stall_run = $urandom_range(0, 7);
    end
  end

  function automatic void note_mismatch(input string what, input longint exp_v,
                                        input longint got_v);
    errors++;
    if (errors <= REPORT_LIMIT)
      $display("%0t: %s expected %0d got %0d", $realtime, what, exp_v, got_v);
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_checked++;
      if (pending_drives.size() == 0) begin
        note_mismatch("result transfer with nothing outstanding, drive_left", 0, drive_left);
      end else begin
        want = pending_drives.pop_front();
        if (drive_left !== want.left) note_mismatch("drive_left", want.left, drive_left);
        if (drive_right !== want.right) note_mismatch("drive_right", want.right, drive_right);
        if (stopped !== want.halted) note_mismatch("stopped", want.halted, stopped);
      end
    end
  end

  // watchdog: too long without a transfer on either channel ends the run
  initial begin
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
    $display("balance_robot_drive_controller: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    tick_item_t    it;
    drive_result_t blank;
    cfg_t          phase_cfg;
    int            trend;
    blank = '{default: '0};
    trend = 0;
    gain_cfg   = cfg_defaults();
    motors_off = 1'b0;
    speed_lp   = 0;
    speed_sum  = 0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table at the reset settings; encoders stay at zero until the clamp rows
    // have run, so the velocity term is still zero there
    directed_rows.push_back(dir_row(OP_TICK,   -896,   0,     0,     0, 1,     0, 0));
    directed_rows.push_back(dir_row(OP_TICK,   8960,   0,     0,     0, 1,  7200, 0));
    directed_rows.push_back(dir_row(OP_TICK,  -8960,   0,     0,     0, 1, -7200, 0));
    // just past the tilt limit: trips and latches
    directed_rows.push_back(dir_row(OP_TICK,   8961,   0,     0,     0, 1,     0, 1));
    directed_rows.push_back(dir_row(OP_TICK,      0,   0,     0,     0, 1,     0, 1));
    directed_rows.push_back(dir_row(OP_RUN,       0,   0,     0,     0, 1,     0, 0));
    directed_rows.push_back(dir_row(OP_TOGGLE,    0,   0,     0,     0, 1,     0, 1));
    directed_rows.push_back(dir_row(OP_TOGGLE,    0,   0,     0,     0, 1,     0, 0));
    directed_rows.push_back(dir_row(OP_STOP,      0,   0,     0,     0, 1,     0, 1));
    directed_rows.push_back(dir_row(OP_STOP,      0,   0,     0,     0, 1,     0, 1));
    // stopped tick at the field extremes: zero drive, filter still runs
    directed_rows.push_back(dir_row(OP_TICK,  46080, 32767, 32767, 32767, 1,  0, 1));
    directed_rows.push_back(dir_row(OP_RUN,       0,   0,     0,     0, 1,     0, 0));
    directed_rows.push_back(dir_row(OP_TICK,  -8961,   0,     0,     0, 1,     0, 1));
    directed_rows.push_back(dir_row(OP_RUN,       0,   0,     0,     0, 1,     0, 0));
    directed_rows.push_back(dir_row(OP_TICK,      0, -32768, -32768, -32768, 0, 0, 0));
    directed_rows.push_back(dir_row(OP_TICK,   -896, 32767, 32767, -32768, 0,  0, 0));
    directed_rows.push_back(dir_row(OP_TICK,    100,   0, 32767, 32767, 0,     0, 0));
    repeat (4) directed_rows.push_back(dir_row(OP_TICK, 0, 100, 32767, 32767, 0, 0, 0));
    directed_rows.push_back(dir_row(OP_TICK, -46080,   0,     0,     0, 1,     0, 1));
    directed_rows.push_back(dir_row(OP_RUN,       0,   0,     0,     0, 1,     0, 0));
    directed_rows.push_back(dir_row(OP_TICK,   1000,  -1,    -1,    -1, 0,     0, 0));
    foreach (directed_rows[i])
      run_item(directed_rows[i].item, directed_rows[i].known, directed_rows[i].result);

    // random phases; phases 1 to 4 under their own register settings, the others at the defaults
    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      phase_cfg = cfg_defaults();
      case (ph)
        1: begin
          // every gain and limit at its top
          phase_cfg.balance_offset = 17'sd46080;
          phase_cfg.bal_p_gain     = 16'hffff;
          phase_cfg.bal_d_gain     = 16'hffff;
          phase_cfg.vel_p_gain     = 16'hffff;
          phase_cfg.vel_i_gain     = 16'hffff;
          phase_cfg.max_drive      = 16'hffff;
          phase_cfg.tilt_limit     = 16'd46080;
        end
        2: begin
          // everything at the bottom, zero drive limit and zero tilt limit
          phase_cfg.balance_offset = -17'sd46080;
          phase_cfg.bal_p_gain     = '0;
          phase_cfg.bal_d_gain     = '0;
          phase_cfg.vel_p_gain     = '0;
          phase_cfg.vel_i_gain     = '0;
          phase_cfg.max_drive      = '0;
          phase_cfg.tilt_limit     = '0;
        end
        3: begin
          // moderate gains so the drive often sits inside its limit
          phase_cfg.balance_offset = 17'(int'($urandom_range(0, 4000)) - 2000);
          phase_cfg.bal_p_gain     = 16'($urandom_range(0, 8192));
          phase_cfg.bal_d_gain     = 16'($urandom_range(0, 1024));
          phase_cfg.vel_p_gain     = 16'($urandom_range(0, 2048));
          phase_cfg.vel_i_gain     = 16'($urandom_range(0, 4096));
          phase_cfg.max_drive      = 16'($urandom_range(1000, 30000));
          phase_cfg.tilt_limit     = 16'($urandom_range(4000, 20000));
        end
        4: begin
          phase_cfg.balance_offset = 17'(int'($urandom_range(0, 92160)) - 46080);
          phase_cfg.bal_p_gain     = 16'($urandom());
          phase_cfg.bal_d_gain     = 16'($urandom());
          phase_cfg.vel_p_gain     = 16'($urandom());
          phase_cfg.vel_i_gain     = 16'($urandom());
          phase_cfg.max_drive      = 16'($urandom());
          phase_cfg.tilt_limit     = 16'($urandom_range(0, 46080));
        end
        default: ;
      endcase
      write_all(phase_cfg);
      idle_on = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // switch idling off for stretches now and then
        if ($urandom_range(0, 49) == 0) idle_on = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 29) == 0) trend = pick_trend();
        it = random_item(trend);
        run_item(it, 1'b0, blank);
      end
    end

    settle();
    $display("covered %0d control ticks and %0d stop commands over %0d register settings",
             ticks_sent, commands_sent, N_PHASES + 1);
    $display("%0d results compared, %0d disagreements, %0d still outstanding",
             results_checked, errors, pending_drives.size());
    if (errors == 0 && pending_drives.size() == 0) begin
      $display("balance_robot_drive_controller: match");
    end else begin
      $display("balance_robot_drive_controller: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/brdc_pkg.sv
rtl/brdc_regs.sv
rtl/brdc_ctrl.sv
rtl/brdc_dp.sv
rtl/balance_robot_drive_controller.sv
tb/balance_robot_drive_controller_tb.sv
